// File: rtl/core/i2cee_pkg.sv
package i2cee_pkg;

   // bus phases, one-hot
   typedef enum logic [19:0] {
      PH_IDLE       = 20'h00001,
      PH_ST_SDA_HI  = 20'h00002,
      PH_ST_SCL_HI  = 20'h00004,
      PH_ST_SDA_LO  = 20'h00008,
      PH_ST_SCL_LO  = 20'h00010,
      PH_WR_SCL_LO  = 20'h00020,
      PH_WR_SDA     = 20'h00040,
      PH_WR_SCL_HI  = 20'h00080,
      PH_WR_END_SCL = 20'h00100,
      PH_WR_END_SDA = 20'h00200,
      PH_ACK_SCL_HI = 20'h00400,
      PH_ACK_WAIT   = 20'h00800,
      PH_RD_SCL_LO  = 20'h01000,
      PH_RD_SDA_REL = 20'h02000,
      PH_RD_SCL_HI  = 20'h04000,
      PH_RD_SCL_LO2 = 20'h08000,
      PH_SP_SDA_LO  = 20'h10000,
      PH_SP_SCL_HI  = 20'h20000,
      PH_SP_SDA_HI  = 20'h40000,
      PH_RECOVER    = 20'h80000
   } phase_type;

   // which byte of the transaction is under way
   typedef enum logic [1:0] {
      SEG_CONTROL = 2'd0,
      SEG_ADDRESS = 2'd1,
      SEG_DATA    = 2'd2
   } seg_type;

   localparam logic [1:0] CSR_WIDE_MODE    = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_READ_RECOV   = 2'd2;
   localparam logic [1:0] CSR_WRITE_RECOV  = 2'd3;

   localparam logic [7:0] CTRL_WRITE = 8'hA0;
   localparam logic [7:0] CTRL_READ  = 8'hA1;

   localparam logic [7:0] ACK_TIMEOUT_RST = 8'd255;
   localparam logic [7:0] READ_RECOV_RST  = 8'd10;
   localparam logic [7:0] WRITE_RECOV_RST = 8'd50;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       wide_address_mode;
      logic [7:0] ack_timeout;
      logic [7:0] read_recovery_ticks;
      logic [7:0] write_recovery_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      seg_type     seg;
      logic [3:0]  bit_count;
      logic [7:0]  shift_reg;
      logic [10:0] held_address;
      logic [7:0]  held_data;
      logic        held_write;
      logic [7:0]  wait_count;
      logic        scl_level;
      logic        sda_level;
   } state_type;

   typedef struct packed {
      logic       kind;
      logic       is_write;
      logic [10:0] mem_address;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
   } rd_type;

endpackage

// File: rtl/core/i2cee_step.sv
module i2cee_step (
   input  i2cee_pkg::cfg_type   cfg,
   input  i2cee_pkg::state_type cur,
   input  i2cee_pkg::req_type   req,
   output i2cee_pkg::state_type nxt,
   output i2cee_pkg::rd_type    rd
);

   logic [3:0] block_bits;
   logic [3:0] bit_count_inc;

   // address bits 10:8 land in control bits 3:1
   assign block_bits    = cfg.wide_address_mode ? {cur.held_address[10:8], 1'b0} : 4'd0;
   assign bit_count_inc = cur.bit_count + 4'd1;

   always_comb begin
      nxt = cur;
      rd  = '0;
      if (req.kind) begin
         if (cur.phase == i2cee_pkg::PH_IDLE) begin
            nxt.held_write   = req.is_write;
            nxt.held_address = req.mem_address;
            nxt.held_data    = req.write_byte;
            nxt.seg          = i2cee_pkg::SEG_CONTROL;
            nxt.phase        = i2cee_pkg::PH_ST_SDA_HI;
         end
      end else begin
         unique case (cur.phase)
            i2cee_pkg::PH_IDLE: begin
               nxt.phase = i2cee_pkg::PH_IDLE;
            end
            i2cee_pkg::PH_ST_SDA_HI: begin
               nxt.sda_level = 1'b1;
               nxt.phase     = i2cee_pkg::PH_ST_SCL_HI;
            end
            i2cee_pkg::PH_ST_SCL_HI: begin
               nxt.scl_level = 1'b1;
               nxt.phase     = i2cee_pkg::PH_ST_SDA_LO;
            end
            i2cee_pkg::PH_ST_SDA_LO: begin
               nxt.sda_level = 1'b0;
               nxt.phase     = i2cee_pkg::PH_ST_SCL_LO;
            end
            i2cee_pkg::PH_ST_SCL_LO: begin
               nxt.scl_level = 1'b0;
               nxt.shift_reg = ((cur.seg == i2cee_pkg::SEG_CONTROL) ?
                                i2cee_pkg::CTRL_WRITE : i2cee_pkg::CTRL_READ)
                               | {4'd0, block_bits};
               nxt.bit_count = 4'd0;
               nxt.phase     = i2cee_pkg::PH_WR_SCL_LO;
            end
            i2cee_pkg::PH_WR_SCL_LO: begin
               nxt.scl_level = 1'b0;
               nxt.phase     = i2cee_pkg::PH_WR_SDA;
            end
            i2cee_pkg::PH_WR_SDA: begin
               nxt.sda_level = cur.shift_reg[7];
               nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
               nxt.phase     = i2cee_pkg::PH_WR_SCL_HI;
            end
            i2cee_pkg::PH_WR_SCL_HI: begin
               nxt.scl_level = 1'b1;
               nxt.bit_count = bit_count_inc;
               nxt.phase     = (bit_count_inc >= i2cee_pkg::BITS_PER_BYTE) ?
                               i2cee_pkg::PH_WR_END_SCL : i2cee_pkg::PH_WR_SCL_LO;
            end
            i2cee_pkg::PH_WR_END_SCL: begin
               nxt.scl_level = 1'b0;
               nxt.phase     = i2cee_pkg::PH_WR_END_SDA;
            end
            i2cee_pkg::PH_WR_END_SDA: begin
               nxt.sda_level = 1'b1;
               nxt.phase     = i2cee_pkg::PH_ACK_SCL_HI;
            end
            i2cee_pkg::PH_ACK_SCL_HI: begin
               nxt.scl_level  = 1'b1;
               nxt.wait_count = 8'd0;
               nxt.phase      = i2cee_pkg::PH_ACK_WAIT;
            end
            i2cee_pkg::PH_ACK_WAIT: begin
               if (!req.sda_in || (cur.wait_count >= cfg.ack_timeout)) begin
                  nxt.scl_level = 1'b0;
                  unique case (cur.seg)
                     i2cee_pkg::SEG_CONTROL: begin
                        nxt.seg       = i2cee_pkg::SEG_ADDRESS;
                        nxt.shift_reg = cur.held_address[7:0];
                        nxt.bit_count = 4'd0;
                        nxt.phase     = i2cee_pkg::PH_WR_SCL_LO;
                     end
                     i2cee_pkg::SEG_ADDRESS: begin
                        nxt.seg = i2cee_pkg::SEG_DATA;
                        if (cur.held_write) begin
                           nxt.shift_reg = cur.held_data;
                           nxt.bit_count = 4'd0;
                           nxt.phase     = i2cee_pkg::PH_WR_SCL_LO;
                        end else begin
                           // repeated start
                           nxt.phase = i2cee_pkg::PH_ST_SDA_HI;
                        end
                     end
                     default: begin
                        nxt.phase = cur.held_write ? i2cee_pkg::PH_SP_SDA_LO :
                                                     i2cee_pkg::PH_RD_SCL_LO;
                     end
                  endcase
               end else begin
                  nxt.wait_count = cur.wait_count + 8'd1;
               end
            end
            i2cee_pkg::PH_RD_SCL_LO: begin
               nxt.scl_level = 1'b0;
               nxt.phase     = i2cee_pkg::PH_RD_SDA_REL;
            end
            i2cee_pkg::PH_RD_SDA_REL: begin
               nxt.sda_level = 1'b1;
               nxt.bit_count = 4'd0;
               nxt.shift_reg = 8'd0;
               nxt.phase     = i2cee_pkg::PH_RD_SCL_HI;
            end
            i2cee_pkg::PH_RD_SCL_HI: begin
               nxt.scl_level = 1'b1;
               nxt.shift_reg = {cur.shift_reg[6:0], req.sda_in};
               nxt.phase     = i2cee_pkg::PH_RD_SCL_LO2;
            end
            i2cee_pkg::PH_RD_SCL_LO2: begin
               nxt.scl_level = 1'b0;
               nxt.bit_count = bit_count_inc;
               nxt.phase     = (bit_count_inc >= i2cee_pkg::BITS_PER_BYTE) ?
                               i2cee_pkg::PH_SP_SDA_LO : i2cee_pkg::PH_RD_SCL_HI;
            end
            i2cee_pkg::PH_SP_SDA_LO: begin
               nxt.sda_level = 1'b0;
               nxt.phase     = i2cee_pkg::PH_SP_SCL_HI;
            end
            i2cee_pkg::PH_SP_SCL_HI: begin
               nxt.scl_level = 1'b1;
               nxt.phase     = i2cee_pkg::PH_SP_SDA_HI;
            end
            i2cee_pkg::PH_SP_SDA_HI: begin
               nxt.sda_level = 1'b1;
               if (!cur.held_write) begin
                  rd.read_valid = 1'b1;
                  rd.read_byte  = cur.shift_reg;
               end
               nxt.wait_count = cur.held_write ? cfg.write_recovery_ticks :
                                                 cfg.read_recovery_ticks;
               nxt.phase      = (nxt.wait_count != 8'd0) ? i2cee_pkg::PH_RECOVER :
                                                           i2cee_pkg::PH_IDLE;
            end
            i2cee_pkg::PH_RECOVER: begin
               if (cur.wait_count != 8'd0) begin
                  nxt.wait_count = cur.wait_count - 8'd1;
               end
               if (nxt.wait_count == 8'd0) begin
                  nxt.phase = i2cee_pkg::PH_IDLE;
               end
            end
            default: begin
               nxt.phase = i2cee_pkg::PH_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/i2c_eeprom_byte_access_master.sv
// each result word is registered in the output register as its request word is accepted;
// throughput is one word per cycle, set by the combinational phase update
// and the output register, which takes a new word whenever it is empty or being drained.
// synchronous active-high reset restores register defaults, releases scl and sda high,
// returns the sequencer to idle and empties the output register.
module i2c_eeprom_byte_access_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // is_write, mem_address[10:0], write_byte[7:0], sda_in
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // scl_out, sda_out, busy_res, read_valid, read_byte[7:0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   i2cee_pkg::cfg_type   cfg_ff;
   i2cee_pkg::state_type state_ff;
   i2cee_pkg::state_type state_in;
   i2cee_pkg::req_type   req;
   i2cee_pkg::rd_type    rd;
   logic                 rsp_valid_ff;
   logic [11:0]          rsp_data_ff;
   logic [11:0]          rsp_data_in;
   logic                 accept;

   assign req.kind        = req_tuser;
   assign req.is_write    = req_tdata[0];
   assign req.mem_address = req_tdata[11:1];
   assign req.write_byte  = req_tdata[19:12];
   assign req.sda_in      = req_tdata[20];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   i2cee_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req),
      .nxt (state_in),
      .rd  (rd)
   );

   assign rsp_data_in = {rd.read_byte, rd.read_valid,
                         (state_in.phase != i2cee_pkg::PH_IDLE),
                         state_in.sda_level, state_in.scl_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide_address_mode    <= 1'b0;
         cfg_ff.ack_timeout          <= i2cee_pkg::ACK_TIMEOUT_RST;
         cfg_ff.read_recovery_ticks  <= i2cee_pkg::READ_RECOV_RST;
         cfg_ff.write_recovery_ticks <= i2cee_pkg::WRITE_RECOV_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cee_pkg::CSR_WIDE_MODE:   cfg_ff.wide_address_mode    <= csr_wdata[0];
            i2cee_pkg::CSR_ACK_TIMEOUT: cfg_ff.ack_timeout          <= csr_wdata;
            i2cee_pkg::CSR_READ_RECOV:  cfg_ff.read_recovery_ticks  <= csr_wdata;
            i2cee_pkg::CSR_WRITE_RECOV: cfg_ff.write_recovery_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= i2cee_pkg::PH_IDLE;
         state_ff.seg          <= i2cee_pkg::SEG_CONTROL;
         state_ff.bit_count    <= 4'd0;
         state_ff.shift_reg    <= 8'd0;
         state_ff.held_address <= 11'd0;
         state_ff.held_data    <= 8'd0;
         state_ff.held_write   <= 1'b0;
         state_ff.wait_count   <= 8'd0;
         state_ff.scl_level    <= 1'b1;
         state_ff.sda_level    <= 1'b1;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

endmodule
